FILE: design/fdrq_pkg.sv
package fdrq_pkg;

    // Queue geometry and field widths.
    localparam int QUEUE_DEPTH = 16;
    localparam int VALUE_BITS  = 32;
    localparam int PTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int TICK_BITS   = 32;
    localparam int DELAY_BITS  = 16;
    localparam int MODE_BITS   = 2;
    localparam int STATUS_BITS = 3;
    localparam int IO_VALUE_BITS = 32;

    // One stored entry: the value and the tick at which it may leave.
    localparam int ENTRY_BITS = VALUE_BITS + TICK_BITS;

    typedef logic [PTR_BITS-1:0]    ptr_t;
    typedef logic [CNT_BITS-1:0]    cnt_t;
    typedef logic [TICK_BITS-1:0]   tick_t;
    typedef logic [VALUE_BITS-1:0]  value_t;
    typedef logic [MODE_BITS-1:0]   mode_t;
    typedef logic [STATUS_BITS-1:0] status_t;

    typedef struct packed {
        value_t value;
        tick_t  release_time;
    } entry_t;

    // Input word operations.
    localparam mode_t MODE_TICK = 2'd0;
    localparam mode_t MODE_PUSH = 2'd1;
    localparam mode_t MODE_POP  = 2'd2;

    // Result status codes.
    localparam status_t STATUS_OK      = 3'd0;
    localparam status_t STATUS_POPPED  = 3'd1;
    localparam status_t STATUS_NOT_DUE = 3'd2;
    localparam status_t STATUS_EMPTY   = 3'd3;
    localparam status_t STATUS_FULL    = 3'd4;

    // Advance a ring pointer, wrapping at the last slot.
    function automatic ptr_t next_slot(input ptr_t p);
        next_slot = (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + ptr_t'(1);
    endfunction

endpackage

FILE: design/fdrq_entry_ram.sv
module fdrq_entry_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64,
    parameter int ADDR_BITS = 4
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/fdrq_due_check.sv
module fdrq_due_check (
    input  fdrq_pkg::tick_t release_time,
    input  fdrq_pkg::tick_t now_ticks,
    output logic            due
);

    fdrq_pkg::tick_t diff;

    // The entry is due when release minus now, read as two's complement,
    // is zero or negative. This stays correct across counter wrap.
    assign diff = release_time - now_ticks;
    assign due  = (diff == '0) || diff[fdrq_pkg::TICK_BITS-1];

endmodule

FILE: design/fixed_delay_release_queue_unit.sv
// Result timing: tick, push and unused words give their result word in the cycle after acceptance;
// a pop of a non-empty queue reads the entry RAM, then compares and loads the result register.
// Throughput: 1 word per cycle for tick and push while the result register is free; a pop
// that reads the entry RAM holds off the next word while it waits in ST_POP for the read.
// Reset: aresetn is synchronous, active low; it empties the queue and clears the tick
// counter and delay register. The entry RAM is not cleared; only written slots are read.
module fixed_delay_release_queue_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Configuration write channel.
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fdrq_pkg::DELAY_BITS-1:0]       cfg_data,
    // Input channel.
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  fdrq_pkg::mode_t                       s_mode,
    input  logic [fdrq_pkg::IO_VALUE_BITS-1:0]    s_item_value,
    // Result channel.
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output fdrq_pkg::status_t                     m_status,
    output logic [fdrq_pkg::IO_VALUE_BITS-1:0]    m_out_value,
    output fdrq_pkg::cnt_t                        m_occupancy
);

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } state_t;

    state_t                             state_reg;
    fdrq_pkg::tick_t                    now_reg;
    fdrq_pkg::ptr_t                     head_reg;
    fdrq_pkg::ptr_t                     tail_reg;
    fdrq_pkg::cnt_t                     count_reg;
    logic [fdrq_pkg::DELAY_BITS-1:0]    delay_reg;
    logic                               m_valid_reg;
    fdrq_pkg::status_t                  m_status_reg;
    logic [fdrq_pkg::IO_VALUE_BITS-1:0] m_value_reg;
    fdrq_pkg::cnt_t                     m_occ_reg;

    logic              out_free;
    logic              in_fire;
    logic              queue_full;
    logic              queue_empty;
    logic              ram_wr_en;
    logic              ram_rd_en;
    fdrq_pkg::entry_t  wr_entry;
    fdrq_pkg::entry_t  rd_entry;
    logic              head_due;

    // The result register is free when it is empty or being drained.
    assign out_free    = !m_valid_reg || m_ready;
    assign s_ready     = (state_reg == ST_IDLE) && out_free;
    assign in_fire     = s_valid && s_ready;
    assign cfg_ready   = 1'b1;
    assign queue_full  = (count_reg == fdrq_pkg::CNT_BITS'(fdrq_pkg::QUEUE_DEPTH));
    assign queue_empty = (count_reg == '0);

    // Push writes the tail slot; pop reads the head slot.
    assign ram_wr_en = in_fire && (s_mode == fdrq_pkg::MODE_PUSH) && !queue_full;
    assign ram_rd_en = in_fire && (s_mode == fdrq_pkg::MODE_POP) && !queue_empty;
    assign wr_entry.value        = s_item_value[fdrq_pkg::VALUE_BITS-1:0];
    assign wr_entry.release_time = now_reg + fdrq_pkg::TICK_BITS'(delay_reg);

    fdrq_entry_ram #(
        .DEPTH     (fdrq_pkg::QUEUE_DEPTH),
        .WIDTH     (fdrq_pkg::ENTRY_BITS),
        .ADDR_BITS (fdrq_pkg::PTR_BITS)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (tail_reg),
        .wr_data (wr_entry),
        .rd_en   (ram_rd_en),
        .rd_addr (head_reg),
        .rd_data (rd_entry)
    );

    fdrq_due_check u_due_check (
        .release_time (rd_entry.release_time),
        .now_ticks    (now_reg),
        .due          (head_due)
    );

    // Sequencer, queue pointers and the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            now_reg     <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            delay_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                delay_reg <= cfg_data;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        m_value_reg <= '0;
                        case (s_mode)
                            fdrq_pkg::MODE_TICK: begin
                                now_reg      <= now_reg + fdrq_pkg::tick_t'(1);
                                m_status_reg <= fdrq_pkg::STATUS_OK;
                                m_occ_reg    <= count_reg;
                                m_valid_reg  <= 1'b1;
                            end
                            fdrq_pkg::MODE_PUSH: begin
                                m_valid_reg <= 1'b1;
                                if (queue_full) begin
                                    m_status_reg <= fdrq_pkg::STATUS_FULL;
                                    m_occ_reg    <= count_reg;
                                end else begin
                                    tail_reg     <= fdrq_pkg::next_slot(tail_reg);
                                    count_reg    <= count_reg + fdrq_pkg::cnt_t'(1);
                                    m_occ_reg    <= count_reg + fdrq_pkg::cnt_t'(1);
                                    m_status_reg <= fdrq_pkg::STATUS_OK;
                                end
                            end
                            fdrq_pkg::MODE_POP: begin
                                if (queue_empty) begin
                                    m_status_reg <= fdrq_pkg::STATUS_EMPTY;
                                    m_occ_reg    <= count_reg;
                                    m_valid_reg  <= 1'b1;
                                end else begin
                                    // Head entry arrives from the RAM next cycle; the
                                    // result register stays empty until then.
                                    m_valid_reg <= 1'b0;
                                    state_reg   <= ST_POP;
                                end
                            end
                            default: begin
                                m_status_reg <= fdrq_pkg::STATUS_OK;
                                m_occ_reg    <= count_reg;
                                m_valid_reg  <= 1'b1;
                            end
                        endcase
                    end else if (m_ready) begin
                        // Drop the result once it has been taken.
                        m_valid_reg <= 1'b0;
                    end
                end
                ST_POP: begin
                    // The result register was freed when the pop was taken.
                    m_valid_reg <= 1'b1;
                    state_reg   <= ST_IDLE;
                    if (head_due) begin
                        head_reg     <= fdrq_pkg::next_slot(head_reg);
                        count_reg    <= count_reg - fdrq_pkg::cnt_t'(1);
                        m_occ_reg    <= count_reg - fdrq_pkg::cnt_t'(1);
                        m_status_reg <= fdrq_pkg::STATUS_POPPED;
                        m_value_reg  <= fdrq_pkg::IO_VALUE_BITS'(rd_entry.value);
                    end else begin
                        m_occ_reg    <= count_reg;
                        m_status_reg <= fdrq_pkg::STATUS_NOT_DUE;
                        m_value_reg  <= '0;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_out_value = m_value_reg;
    assign m_occupancy = m_occ_reg;

    // The queue never holds more than its depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= fdrq_pkg::CNT_BITS'(fdrq_pkg::QUEUE_DEPTH))
        else $error("entry count exceeds queue depth");

    // A pending result always reports the current occupancy.
    a_occ_tracks_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_occ_reg == count_reg))
        else $error("reported occupancy differs from entry count");

    // Only a popped word carries a nonzero value.
    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg != fdrq_pkg::STATUS_POPPED)) |-> (m_value_reg == '0))
        else $error("nonzero value on a word that is not a pop");

    // A pop that reads the RAM passes through ST_POP and then completes.
    a_pop_completes: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_rd_en |=> ((state_reg == ST_POP) ##1 (m_valid_reg && (state_reg == ST_IDLE))))
        else $error("pop did not complete after the entry read");

endmodule

FILE: dv/fixed_delay_release_queue_checker.sv
`timescale 1ns / 100ps

module fixed_delay_release_queue_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [fdrq_pkg::DELAY_BITS-1:0]      cfg_data,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  fdrq_pkg::mode_t                      s_mode,
    input  logic [fdrq_pkg::IO_VALUE_BITS-1:0]   s_item_value,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  fdrq_pkg::status_t                    m_status,
    input  logic [fdrq_pkg::IO_VALUE_BITS-1:0]   m_out_value,
    input  fdrq_pkg::cnt_t                       m_occupancy,
    output int                                   fail_count,
    output int                                   pending_words
);

    // One predicted result word.
    typedef struct {
        fdrq_pkg::status_t                    status;
        logic [fdrq_pkg::IO_VALUE_BITS-1:0]   value;
        fdrq_pkg::cnt_t                       occupancy;
    } release_word_t;

    // Shadow copy of the queue state and the delay register.
    fdrq_pkg::tick_t                   shadow_now;
    logic [fdrq_pkg::DELAY_BITS-1:0]   shadow_delay;
    fdrq_pkg::value_t                  shadow_values [fdrq_pkg::QUEUE_DEPTH];
    fdrq_pkg::tick_t                   shadow_release [fdrq_pkg::QUEUE_DEPTH];
    int unsigned                       shadow_head;
    int unsigned                       shadow_tail;
    int unsigned                       shadow_count;

    release_word_t                     expected_words [$];

    initial begin
        fail_count = 0;
        pending_words = 0;
    end

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        $display("ERROR at %0t ns: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    // Applies one input word to the shadow queue and returns the result it must give.
    function automatic release_word_t apply_queue_word(
        input fdrq_pkg::mode_t mode,
        input logic [fdrq_pkg::IO_VALUE_BITS-1:0] item);
        release_word_t   w;
        fdrq_pkg::tick_t gap;
        w.status = fdrq_pkg::STATUS_OK;
        w.value = '0;
        case (mode)
            fdrq_pkg::MODE_TICK: begin
                shadow_now = shadow_now + fdrq_pkg::tick_t'(1);
            end
            fdrq_pkg::MODE_PUSH: begin
                if (shadow_count >= fdrq_pkg::QUEUE_DEPTH) begin
                    w.status = fdrq_pkg::STATUS_FULL;
                end else begin
                    shadow_values[shadow_tail] = fdrq_pkg::value_t'(item);
                    shadow_release[shadow_tail] =
                        shadow_now + fdrq_pkg::tick_t'(shadow_delay);
                    shadow_tail = (shadow_tail == fdrq_pkg::QUEUE_DEPTH - 1) ?
                                  0 : shadow_tail + 1;
                    shadow_count++;
                end
            end
            fdrq_pkg::MODE_POP: begin
                if (shadow_count == 0) begin
                    w.status = fdrq_pkg::STATUS_EMPTY;
                end else begin
                    // Due once release minus now is zero or negative as a signed number.
                    gap = shadow_release[shadow_head] - shadow_now;
                    if ($signed(gap) > 0) begin
                        w.status = fdrq_pkg::STATUS_NOT_DUE;
                    end else begin
                        w.status = fdrq_pkg::STATUS_POPPED;
                        w.value = fdrq_pkg::IO_VALUE_BITS'(shadow_values[shadow_head]);
                        shadow_head = (shadow_head == fdrq_pkg::QUEUE_DEPTH - 1) ?
                                      0 : shadow_head + 1;
                        shadow_count--;
                    end
                end
            end
            default: begin
                // The spare mode leaves everything as it is.
            end
        endcase
        w.occupancy = fdrq_pkg::cnt_t'(shadow_count);
        return w;
    endfunction

    // Watch all three channels; outputs are compared before new words are predicted.
    always @(posedge aclk) begin
        release_word_t want;
        if (!aresetn) begin
            shadow_now = '0;
            shadow_delay = '0;
            shadow_head = 0;
            shadow_tail = 0;
            shadow_count = 0;
            expected_words.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                shadow_delay = cfg_data;
            end
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("result word with none expected", 32'(m_status), 32'hx);
                end else begin
                    want = expected_words.pop_front();
                    if (m_status !== want.status) begin
                        report_mismatch("status", 32'(m_status), 32'(want.status));
                    end
                    if (m_out_value !== want.value) begin
                        report_mismatch("out_value", m_out_value, want.value);
                    end
                    if (m_occupancy !== want.occupancy) begin
                        report_mismatch("occupancy", 32'(m_occupancy), 32'(want.occupancy));
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_words.push_back(apply_queue_word(s_mode, s_item_value));
            end
        end
        pending_words <= expected_words.size();
    end

endmodule

FILE: dv/fixed_delay_release_queue_unit_test.sv
`timescale 1ns / 100ps

module fixed_delay_release_queue_unit_test;

    // The fourth mode code has no name in the package.
    localparam fdrq_pkg::mode_t MODE_SPARE = 2'd3;
    localparam int              CYCLE_LIMIT = 300000;
    localparam int              HOLD_CYCLES = 300;

    logic                                 aclk = 1'b0;
    logic                                 aresetn = 1'b0;
    logic                                 cfg_valid = 1'b0;
    logic                                 cfg_ready;
    logic [fdrq_pkg::DELAY_BITS-1:0]      cfg_data = '0;
    logic                                 s_valid = 1'b0;
    logic                                 s_ready;
    fdrq_pkg::mode_t                      s_mode = fdrq_pkg::MODE_TICK;
    logic [fdrq_pkg::IO_VALUE_BITS-1:0]   s_item_value = '0;
    logic                                 m_valid;
    logic                                 m_ready = 1'b0;
    fdrq_pkg::status_t                    m_status;
    logic [fdrq_pkg::IO_VALUE_BITS-1:0]   m_out_value;
    fdrq_pkg::cnt_t                       m_occupancy;

    int                         fail_count;
    int                         pending_words;
    int                         cycle_count = 0;
    bit                         hold_request = 1'b0;

    fixed_delay_release_queue_unit i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_item_value (s_item_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_out_value  (m_out_value),
        .m_occupancy  (m_occupancy)
    );

    fixed_delay_release_queue_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_item_value  (s_item_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_out_value   (m_out_value),
        .m_occupancy   (m_occupancy),
        .fail_count    (fail_count),
        .pending_words (pending_words)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: segments of steady, random or mostly stalled ready, plus one long hold.
    initial begin
        int seg_len;
        int style;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                @(posedge aclk);
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            seg_len = $urandom_range(1, 40);
            style = $urandom_range(0, 2);
            repeat (seg_len) begin
                @(posedge aclk);
                if (style == 0) begin
                    m_ready <= 1'b1;
                end else if (style == 1) begin
                    m_ready <= 1'($urandom_range(0, 1));
                end else begin
                    m_ready <= ($urandom_range(0, 5) == 0);
                end
            end
        end
    end

    // Offer one word and hold it until the block takes it.
    task automatic send_word(input fdrq_pkg::mode_t mode,
                             input logic [fdrq_pkg::IO_VALUE_BITS-1:0] item);
        s_valid <= 1'b1;
        s_mode <= mode;
        s_item_value <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Let every predicted result come out, then write the delay register.
    task automatic write_delay(input logic [fdrq_pkg::DELAY_BITS-1:0] delay);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_words != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= delay;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Random words in bursts; the push and pop mix changes from burst to burst.
    task automatic run_random_phase(input int words, input int min_push, input int max_push);
        int sent;
        int burst;
        int gap;
        int push_w;
        int pop_w;
        int pick;
        fdrq_pkg::mode_t mode;
        logic [fdrq_pkg::IO_VALUE_BITS-1:0] item;
        sent = 0;
        while (sent < words) begin
            burst = $urandom_range(1, 24);
            push_w = $urandom_range(min_push, max_push);
            pop_w = $urandom_range(5, 92 - push_w);
            for (int i = 0; i < burst && sent < words; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    mode = MODE_SPARE;
                end else if (pick < 4 + push_w) begin
                    mode = fdrq_pkg::MODE_PUSH;
                end else if (pick < 4 + push_w + pop_w) begin
                    mode = fdrq_pkg::MODE_POP;
                end else begin
                    mode = fdrq_pkg::MODE_TICK;
                end
                case ($urandom_range(0, 9))
                    0: item = '0;
                    1: item = '1;
                    default: item = $urandom;
                endcase
                send_word(mode, item);
                sent++;
            end
            // Some bursts run straight into the next one.
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Stimulus and verdict.
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Zero delay: empty pop, value extremes, spare mode.
        write_delay(16'd0);
        send_word(fdrq_pkg::MODE_POP, 32'h0);
        send_word(fdrq_pkg::MODE_PUSH, 32'h0000_0000);
        send_word(fdrq_pkg::MODE_PUSH, 32'hFFFF_FFFF);
        send_word(MODE_SPARE, 32'hFFFF_FFFF);
        send_word(fdrq_pkg::MODE_POP, 32'h0);
        send_word(fdrq_pkg::MODE_POP, 32'h0);
        send_word(fdrq_pkg::MODE_POP, 32'h0);

        // Short delay: the head is refused until enough ticks have passed.
        write_delay(16'd2);
        send_word(fdrq_pkg::MODE_PUSH, 32'h5A5A_A5A5);
        send_word(fdrq_pkg::MODE_POP, 32'h0);
        send_word(fdrq_pkg::MODE_TICK, 32'hFFFF_FFFF);
        send_word(fdrq_pkg::MODE_POP, 32'h0);
        send_word(fdrq_pkg::MODE_TICK, 32'h0);
        send_word(fdrq_pkg::MODE_POP, 32'h0);

        // Random phases over several delay settings.
        write_delay(16'd0);
        run_random_phase(200, 20, 60);
        write_delay(16'd1);
        run_random_phase(200, 20, 60);
        write_delay(16'($urandom_range(2, 10)));
        run_random_phase(200, 25, 65);

        // Long result stall that backs up the input, with a push-heavy mix so the queue fills.
        write_delay(16'd2);
        hold_request = 1'b1;
        run_random_phase(180, 60, 85);

        // Large delays last; entries pushed under the largest delay never become due here.
        write_delay(16'hFFFF);
        run_random_phase(80, 20, 60);
        write_delay(16'($urandom_range(0, 65535)));
        run_random_phase(80, 20, 60);

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_words != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
